/* hdl/wss_pkg.sv */
// Package for the window sample statistics block: sizes, field types and
// the controller state type. No dependencies; every other file uses it.
`timescale 1ns / 1ps

package wss_pkg;

  // Storage geometry.
  localparam int WINDOW_DEPTH = 64;
  localparam int CHANNELS     = 8;

  // Fixed field widths of the item and result payloads.
  localparam int SMP_W  = 16;
  localparam int CHAN_W = 3;
  localparam int CNT_W  = 7;

  // Widths that follow from the geometry.
  localparam int POS_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LEN_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int CHIDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RAM_DEPTH = CHANNELS * WINDOW_DEPTH;
  localparam int ADDR_W   = $clog2(RAM_DEPTH);
  localparam int DIV_STEPS = SMP_W;
  localparam int STEP_W   = $clog2(DIV_STEPS + 1);

  typedef logic [SMP_W-1:0]   smp_t;
  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [CHIDX_W-1:0] chidx_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [STEP_W-1:0]  step_t;

  // Window length after reset.
  localparam cnt_t LEN_RESET = cnt_t'(64);

  // Item kinds.
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_DIV,
    S_EMIT
  } state_e;

endpackage

/* hdl/wss_if.sv */
// Handshake channels of the window sample statistics block: input items,
// result items and the window length write port. Depends on wss_pkg.
`timescale 1ns / 1ps

interface wss_in_if;
  logic                valid;
  logic                ready;
  logic                kind;
  wss_pkg::chan_t      channel;
  wss_pkg::smp_t       sample;

  modport source (output valid, kind, channel, sample, input ready);
  modport sink   (input valid, kind, channel, sample, output ready);
endinterface

interface wss_out_if;
  logic                valid;
  logic                ready;
  wss_pkg::smp_t       window_sum;
  wss_pkg::smp_t       window_average;
  wss_pkg::smp_t       window_minimum;
  wss_pkg::smp_t       window_maximum;
  wss_pkg::cnt_t       sample_count;

  modport source (output valid, window_sum, window_average, window_minimum,
                  window_maximum, sample_count, input ready);
  modport sink   (input valid, window_sum, window_average, window_minimum,
                  window_maximum, sample_count, output ready);
endinterface

interface wss_cfg_if;
  logic                valid;
  logic                ready;
  wss_pkg::cnt_t       window_length;

  modport source (output valid, window_length, input ready);
  modport sink   (input valid, window_length, output ready);
endinterface

/* hdl/window_sample_statistics_core.sv */
// Top level of the window sample statistics block: controller, per-channel
// ring pointers and result register. Depends on wss_pkg, wss_if,
// wss_sample_ram and wss_divider.
`timescale 1ns / 1ps

//   Channel   Role     Payload                                        Item taken when
//   in_i      sink     kind, channel, sample                          valid and ready high
//   out_o     source   window_sum, window_average, window_minimum,    valid and ready high
//                      window_maximum, sample_count
//   cfg_i     sink     window_length                                  valid and ready high
//
// An accepted item passes through the update, scan and divide states, and its result is
// loaded in the emit state. The scan reads the samples stored in the channel (up to 64)
// one per cycle from the single read port of the sample memory, and the average takes 16
// divider steps. A clear item or an item for an absent channel skips the scan and divide.
// Reset empties every channel and sets the window length to 64; the sample memory is not
// cleared. A result waiting in the output register does not stop the next item from being
// accepted; it only holds a later result.

module window_sample_statistics_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  wss_in_if.sink           in_i,
  wss_out_if.source        out_o,
  wss_cfg_if.sink          cfg_i
);

  // Controller state.
  wss_pkg::state_e state_q, state_d;

  // Window length register as written, and the length it stands for.
  wss_pkg::cnt_t   len_reg_q;
  wss_pkg::len_t   len_eff;

  // Per-channel ring pointer and fill level.
  wss_pkg::pos_t   wpos_q [wss_pkg::CHANNELS];
  wss_pkg::len_t   fill_q [wss_pkg::CHANNELS];

  // The item being worked on.
  logic            kind_q;
  wss_pkg::chidx_t ch_q;
  logic            ch_ok_q;
  wss_pkg::smp_t   smp_q;

  // Scan and statistics.
  wss_pkg::len_t   count_q, count_d;
  wss_pkg::len_t   iss_q, iss_d;
  logic            rd_pend_q, rd_pend_d;
  wss_pkg::smp_t   sum_q, sum_d;
  wss_pkg::smp_t   min_q, min_d;
  wss_pkg::smp_t   max_q, max_d;

  // Result register.
  logic            out_valid_q, out_valid_d;
  wss_pkg::smp_t   out_sum_q, out_avg_q, out_min_q, out_max_q;
  wss_pkg::cnt_t   out_cnt_q;

  // Controller outputs.
  logic            in_take;
  logic            ram_we;
  logic            ram_re;
  logic            chan_upd;
  logic            scan_done;
  logic            div_start;
  logic            out_load;

  // Ring update arithmetic.
  wss_pkg::pos_t   cur_pos, wr_pos, next_pos;
  wss_pkg::len_t   cur_fill, fill_new, pos_inc;
  wss_pkg::addr_t  wr_addr, rd_addr;
  wss_pkg::smp_t   rd_data;
  wss_pkg::smp_t   sum_fixed;
  logic            div_done;
  wss_pkg::smp_t   div_quo;

  // ---------------------------------------------------------------------------
  // Configuration: a length of zero acts as one, and anything beyond the window
  // depth acts as the depth.
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (len_reg_q == '0) begin
      len_eff = wss_pkg::len_t'(1);
    end else if (int'(len_reg_q) > wss_pkg::WINDOW_DEPTH) begin
      len_eff = wss_pkg::len_t'(wss_pkg::WINDOW_DEPTH);
    end else begin
      len_eff = wss_pkg::len_t'(len_reg_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Ring pointer update. A write position left beyond a shortened window wraps
  // to the first entry before the write.
  // ---------------------------------------------------------------------------
  always_comb begin
    cur_pos  = wpos_q[ch_q];
    cur_fill = fill_q[ch_q];
    wr_pos   = (wss_pkg::len_t'(cur_pos) >= len_eff) ? '0 : cur_pos;
    pos_inc  = wss_pkg::len_t'(wr_pos) + wss_pkg::len_t'(1);
    next_pos = (pos_inc >= len_eff) ? '0 : wss_pkg::pos_t'(pos_inc);
    fill_new = (cur_fill < len_eff) ? cur_fill + wss_pkg::len_t'(1) : len_eff;
    wr_addr  = wss_pkg::addr_t'(ch_q) * wss_pkg::addr_t'(wss_pkg::WINDOW_DEPTH)
             + wss_pkg::addr_t'(wr_pos);
    rd_addr  = wss_pkg::addr_t'(ch_q) * wss_pkg::addr_t'(wss_pkg::WINDOW_DEPTH)
             + wss_pkg::addr_t'(iss_q);
  end

  // The scan is over once every read has been issued and the last one returned.
  assign scan_done = (iss_q == count_q) && !rd_pend_q;

  // The crude overflow test: a wrapped sum shows up as smaller than the maximum.
  assign sum_fixed = (sum_q < max_q) ? '0 : sum_q;

  // ---------------------------------------------------------------------------
  // Controller: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wss_pkg::S_IDLE: begin
        if (in_i.valid) begin
          state_d = wss_pkg::S_UPDATE;
        end
      end
      wss_pkg::S_UPDATE: begin
        if (!ch_ok_q || kind_q == wss_pkg::KIND_CLEAR) begin
          state_d = wss_pkg::S_EMIT;
        end else begin
          state_d = wss_pkg::S_SCAN;
        end
      end
      wss_pkg::S_SCAN: begin
        if (scan_done) begin
          state_d = wss_pkg::S_DIV;
        end
      end
      wss_pkg::S_DIV: begin
        if (div_done) begin
          state_d = wss_pkg::S_EMIT;
        end
      end
      wss_pkg::S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = wss_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wss_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Controller: outputs.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_take   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    chan_upd  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      wss_pkg::S_IDLE: begin
        in_take = 1'b1;
      end
      wss_pkg::S_UPDATE: begin
        chan_upd = ch_ok_q;
        ram_we   = ch_ok_q && (kind_q == wss_pkg::KIND_ADD);
      end
      wss_pkg::S_SCAN: begin
        ram_re    = (iss_q != count_q);
        div_start = scan_done;
      end
      wss_pkg::S_DIV: begin
      end
      wss_pkg::S_EMIT: begin
        out_load = !out_valid_q || out_o.ready;
      end
      default: begin
      end
    endcase
  end

  assign in_i.ready = in_take;

  // ---------------------------------------------------------------------------
  // Statistics datapath.
  // ---------------------------------------------------------------------------
  always_comb begin
    count_d   = count_q;
    iss_d     = iss_q;
    rd_pend_d = ram_re;
    sum_d     = sum_q;
    min_d     = min_q;
    max_d     = max_q;
    if (state_q == wss_pkg::S_UPDATE) begin
      // The window is entries 0 .. count-1; the write just made is among them.
      if (!ch_ok_q || kind_q == wss_pkg::KIND_CLEAR) begin
        count_d = '0;
      end else begin
        count_d = fill_new;
      end
      iss_d = '0;
      sum_d = '0;
      min_d = '1;
      max_d = '0;
    end else begin
      if (ram_re) begin
        iss_d = iss_q + wss_pkg::len_t'(1);
      end
      if (rd_pend_q) begin
        sum_d = sum_q + rd_data;
        if (rd_data < min_q) begin
          min_d = rd_data;
        end
        if (rd_data > max_q) begin
          max_d = rd_data;
        end
      end
      if (div_start) begin
        sum_d = sum_fixed;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wss_pkg::S_IDLE;
      len_reg_q   <= wss_pkg::LEN_RESET;
      wpos_q      <= '{default: '0};
      fill_q      <= '{default: '0};
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        len_reg_q <= cfg_i.window_length;
      end
      if (chan_upd) begin
        if (kind_q == wss_pkg::KIND_CLEAR) begin
          wpos_q[ch_q] <= '0;
          fill_q[ch_q] <= '0;
        end else begin
          wpos_q[ch_q] <= next_pos;
          fill_q[ch_q] <= fill_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && in_i.valid) begin
      kind_q  <= in_i.kind;
      ch_q    <= wss_pkg::chidx_t'(in_i.channel);
      ch_ok_q <= (int'(in_i.channel) < wss_pkg::CHANNELS);
      smp_q   <= in_i.sample;
    end
    count_q <= count_d;
    iss_q   <= iss_d;
    sum_q   <= sum_d;
    min_q   <= min_d;
    max_q   <= max_d;
    if (out_load) begin
      // An empty or absent channel reports all zeros.
      if (count_q == '0) begin
        out_sum_q <= '0;
        out_avg_q <= '0;
        out_min_q <= '0;
        out_max_q <= '0;
        out_cnt_q <= '0;
      end else begin
        out_sum_q <= sum_q;
        out_avg_q <= div_quo;
        out_min_q <= min_q;
        out_max_q <= max_q;
        out_cnt_q <= wss_pkg::cnt_t'(count_q);
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.window_sum     = out_sum_q;
  assign out_o.window_average = out_avg_q;
  assign out_o.window_minimum = out_min_q;
  assign out_o.window_maximum = out_max_q;
  assign out_o.sample_count   = out_cnt_q;

  // ---------------------------------------------------------------------------
  // Sample memory and average divider.
  // ---------------------------------------------------------------------------
  wss_sample_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (smp_q),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  wss_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_fixed),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

endmodule

/* hdl/wss_sample_ram.sv */
// Sample storage of all channel windows: one write port, one read port,
// registered read data. Depends on wss_pkg.
`timescale 1ns / 1ps

module wss_sample_ram (
  input  logic          clk_i,
  input  logic          we_i,
  input  wss_pkg::addr_t waddr_i,
  input  wss_pkg::smp_t  wdata_i,
  input  logic          re_i,
  input  wss_pkg::addr_t raddr_i,
  output wss_pkg::smp_t  rdata_o
);

  wss_pkg::smp_t mem_q [wss_pkg::RAM_DEPTH];
  wss_pkg::smp_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/wss_divider.sv */
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on wss_pkg.
`timescale 1ns / 1ps

module wss_divider (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  wss_pkg::smp_t  dividend_i,
  input  wss_pkg::len_t  divisor_i,
  output logic           done_o,
  output wss_pkg::smp_t  quotient_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  wss_pkg::step_t             step_q, step_d;
  wss_pkg::smp_t              quo_q, quo_d;
  wss_pkg::len_t              rem_q, rem_d;
  wss_pkg::len_t              dvs_q, dvs_d;
  logic [wss_pkg::LEN_W:0]    trial;
  logic [wss_pkg::LEN_W:0]    diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[wss_pkg::SMP_W-1]};
    diff   = trial - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = wss_pkg::step_t'(wss_pkg::DIV_STEPS);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits LEN_W bits.
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[wss_pkg::LEN_W-1:0];
        quo_d = {quo_q[wss_pkg::SMP_W-2:0], 1'b1};
      end else begin
        rem_d = trial[wss_pkg::LEN_W-1:0];
        quo_d = {quo_q[wss_pkg::SMP_W-2:0], 1'b0};
      end
      step_d = step_q - wss_pkg::step_t'(1);
      if (step_q == wss_pkg::step_t'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* tb/sv/window_sample_statistics_core_tb.sv */
// Self-checking testbench for window_sample_statistics_core: a directed table,
// then random phases, each result checked against a predictor of the windows.
// Depends on wss_pkg, the wss_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module window_sample_statistics_core_tb;
  import wss_pkg::*;

  // Stimulus sizes and limits. An item's time inside the block is bounded by its scan and
  // divider steps, and a stall on either side is bounded by stall_length, so a quiet stretch
  // as long as the watchdog limit can only mean a hang.
  localparam int unsigned RANDOM_ITEMS   = 1600;
  localparam int unsigned DRAIN_CYCLES   = 120;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PRINT_LIMIT    = 40;

  // Row kinds of the directed table.
  localparam logic ROW_ITEM   = 1'b0;
  localparam logic ROW_LENGTH = 1'b1;

  // Sample value ranges used by the random phases.
  localparam int unsigned SMP_FULL    = 0;
  localparam int unsigned SMP_LOW     = 1;
  localparam int unsigned SMP_HIGH    = 2;
  localparam int unsigned SMP_EXTREME = 3;

  // One result item, in the order of the output payload.
  typedef struct packed {
    smp_t sum;
    smp_t average;
    smp_t minimum;
    smp_t maximum;
    cnt_t count;
  } stats_t;

  // One row of the directed table. A typed row carries its expected result;
  // every other row is checked against the predictor.
  typedef struct packed {
    logic   what;
    logic   kind;
    chan_t  ch;
    smp_t   smp;
    cnt_t   length;
    logic   typed;
    stats_t want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  wss_in_if  in_if ();
  wss_out_if out_if ();
  wss_cfg_if cfg_if ();

  window_sample_statistics_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Predictor state: a copy of every channel's ring, its write position and
  // fill count, and the window length register. ring_written marks the entries
  // that have held a sample since reset; the block's memory is not cleared, so
  // an entry that was never written must never be read.
  smp_t                    ring_mem     [CHANNELS][WINDOW_DEPTH];
  int unsigned             ring_pos     [CHANNELS];
  int unsigned             ring_fill    [CHANNELS];
  logic [WINDOW_DEPTH-1:0] ring_written [CHANNELS];
  cnt_t                    length_reg;

  // Results still owed by the block, oldest first.
  stats_t      pending_stats [$];
  plan_row_t   plan [$];
  int unsigned mismatch_count;

  // Idling controls, changed from phase to phase.
  bit src_gaps_on;
  bit stalls_on;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The window length in use: 0 acts as 1, and anything above the depth acts
  // as the depth.
  function automatic int unsigned used_length();
    if (length_reg == 0) return 1;
    if (length_reg > WINDOW_DEPTH) return WINDOW_DEPTH;
    return 32'(length_reg);
  endfunction

  // Applies one item to the predicted windows and returns the statistics that
  // the block must report for it.
  function automatic stats_t apply_item(logic kind, chan_t ch, smp_t smp);
    stats_t      r;
    int unsigned len;
    int unsigned pos;
    int unsigned cnt;
    int unsigned i;
    smp_t        v;
    r = '0;
    len = used_length();
    if (ch >= CHANNELS) return r;
    if (kind == KIND_CLEAR) begin
      ring_pos[ch] = 0;
      ring_fill[ch] = 0;
    end else begin
      // A position left beyond a shrunk window wraps before the write.
      pos = ring_pos[ch];
      if (pos >= len) pos = 0;
      ring_mem[ch][pos] = smp;
      ring_written[ch][pos] = 1'b1;
      pos = pos + 1;
      if (pos >= len) pos = 0;
      ring_pos[ch] = pos;
      if (ring_fill[ch] < len) ring_fill[ch] = ring_fill[ch] + 1;
      else ring_fill[ch] = len;
    end
    cnt = (ring_fill[ch] > len) ? len : ring_fill[ch];
    if (cnt == 0) return r;
    r.minimum = ring_mem[ch][0];
    r.maximum = ring_mem[ch][0];
    for (i = 0; i < cnt; i++) begin
      v = ring_mem[ch][i];
      r.sum = r.sum + v;
      if (v < r.minimum) r.minimum = v;
      if (v > r.maximum) r.maximum = v;
    end
    // A wrapped sum that falls below the largest sample is reported as zero.
    if (r.sum < r.maximum) r.sum = '0;
    r.average = smp_t'(r.sum / cnt);
    r.count = cnt_t'(cnt);
    return r;
  endfunction

  // True when an add on this channel reads only entries written since reset.
  // Raising the window length over a filled ring can break this; the random
  // part then sends a clear instead.
  function automatic bit add_is_safe(chan_t ch);
    int unsigned len;
    int unsigned pos;
    int unsigned fill;
    int unsigned i;
    len = used_length();
    pos = ring_pos[ch];
    if (pos >= len) pos = 0;
    fill = (ring_fill[ch] < len) ? ring_fill[ch] + 1 : len;
    for (i = 0; i < fill; i++) begin
      if (i != pos && ring_written[ch][i] !== 1'b1) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned stall_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 75) return $urandom_range(3, 1);
    if (roll < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int unsigned source_gap();
    if (!src_gaps_on || $urandom_range(1) == 0) return 0;
    return stall_length();
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offers one item after a gap and records its expected result once the
  // block takes it. With no gap, valid simply stays high from the last item.
  task automatic send_item(logic kind, chan_t ch, smp_t smp, int unsigned gap,
                           stats_t want);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.kind    <= kind;
    in_if.channel <= ch;
    in_if.sample  <= smp;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    pending_stats.push_back(want);
  endtask

  // The register is written only once the block has delivered every result.
  task automatic write_length(cnt_t value);
    in_if.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_if.valid         <= 1'b1;
    cfg_if.window_length <= value;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    length_reg = value;
  endtask

  task automatic item_row(logic kind, chan_t ch, smp_t smp);
    plan_row_t r;
    r = '0;
    r.what = ROW_ITEM;
    r.kind = kind;
    r.ch   = ch;
    r.smp  = smp;
    plan.push_back(r);
  endtask

  task automatic typed_row(logic kind, chan_t ch, smp_t smp, smp_t sum, smp_t avg,
                           smp_t mn, smp_t mx, cnt_t cnt);
    plan_row_t r;
    r = '0;
    r.what  = ROW_ITEM;
    r.kind  = kind;
    r.ch    = ch;
    r.smp   = smp;
    r.typed = 1'b1;
    r.want  = {sum, avg, mn, mx, cnt};
    plan.push_back(r);
  endtask

  task automatic length_row(cnt_t value);
    plan_row_t r;
    r = '0;
    r.what   = ROW_LENGTH;
    r.length = value;
    plan.push_back(r);
  endtask

  // Result side: the ready line alternates between runs high and stalls. With
  // stalls switched off it stays high once the current stall has run out.
  initial begin : result_ready
    int unsigned run_left;
    out_if.ready <= 1'b0;
    run_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (run_left > 0) begin
        run_left--;
      end else if (out_if.ready === 1'b1 && stalls_on) begin
        out_if.ready <= 1'b0;
        run_left = stall_length();
      end else begin
        out_if.ready <= 1'b1;
        run_left = $urandom_range(12);
      end
    end
  end

  // Every result the block hands over is compared, field by field, with the
  // oldest expectation.
  initial begin : result_checker
    stats_t got;
    stats_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.sum     = out_if.window_sum;
        got.average = out_if.window_average;
        got.minimum = out_if.window_minimum;
        got.maximum = out_if.window_maximum;
        got.count   = out_if.sample_count;
        if (pending_stats.size() == 0) begin
          flag_mismatch("result with no item pending", 64'(got.sum), 64'(0));
        end else begin
          want = pending_stats.pop_front();
          if (got.sum !== want.sum)
            flag_mismatch("window_sum", 64'(got.sum), 64'(want.sum));
          if (got.average !== want.average)
            flag_mismatch("window_average", 64'(got.average), 64'(want.average));
          if (got.minimum !== want.minimum)
            flag_mismatch("window_minimum", 64'(got.minimum), 64'(want.minimum));
          if (got.maximum !== want.maximum)
            flag_mismatch("window_maximum", 64'(got.maximum), 64'(want.maximum));
          if (got.count !== want.count)
            flag_mismatch("sample_count", 64'(got.count), 64'(want.count));
        end
      end
    end
  end

  // Ends the run when no channel has moved an item for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("window_sample_statistics_core verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned ch_i;
    int unsigned items_left;
    int unsigned phase;
    int unsigned phase_items;
    int unsigned n_focus;
    int unsigned clear_pct;
    int unsigned smp_mode;
    int unsigned roll;
    chan_t       focus [3];
    cnt_t        new_length;
    logic        kind;
    chan_t       ch;
    smp_t        smp;
    stats_t      want;

    // Every input is known from the first instant; reset is asserted once at the start and
    // never asserted again.
    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.kind           <= KIND_ADD;
    in_if.channel        <= '0;
    in_if.sample         <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.window_length <= LEN_RESET;
    mismatch_count = 0;
    src_gaps_on = 1'b1;
    stalls_on = 1'b1;
    for (ch_i = 0; ch_i < CHANNELS; ch_i++) begin
      ring_pos[ch_i] = 0;
      ring_fill[ch_i] = 0;
      ring_written[ch_i] = '0;
    end
    length_reg = LEN_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. It starts from the reset length of 64, covers the
    // extreme samples, the overflow test forcing the sum to zero, clearing a
    // filled and an empty channel, a length of 0 acting as 1, a length above
    // the depth, a shrunk length overwriting the oldest sample, and raising
    // the length again over stored data.
    typed_row(KIND_ADD,   3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd1);
    typed_row(KIND_ADD,   3'd0, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0000, 16'hFFFF, 7'd2);
    typed_row(KIND_ADD,   3'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 7'd3);
    typed_row(KIND_CLEAR, 3'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0);
    typed_row(KIND_CLEAR, 3'd7, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0);
    typed_row(KIND_ADD,   3'd7, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 7'd1);
    item_row(KIND_ADD, 3'd7, 16'h1234);
    item_row(KIND_ADD, 3'd3, 16'hAAAA);
    item_row(KIND_ADD, 3'd5, 16'h5555);
    length_row(7'd0);
    typed_row(KIND_ADD,   3'd7, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 7'd1);
    typed_row(KIND_ADD,   3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd1);
    length_row(7'd127);
    item_row(KIND_ADD, 3'd7, 16'h0010);
    length_row(7'd2);
    item_row(KIND_ADD, 3'd3, 16'h0001);
    item_row(KIND_ADD, 3'd3, 16'h0002);
    item_row(KIND_ADD, 3'd3, 16'h0003);
    length_row(7'd64);
    typed_row(KIND_CLEAR, 3'd3, 16'h5A5A, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0);
    typed_row(KIND_ADD,   3'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 7'd1);
    item_row(KIND_ADD, 3'd5, 16'h0001);
    item_row(KIND_ADD, 3'd1, 16'h0003);
    item_row(KIND_ADD, 3'd5, 16'hFFFE);

    foreach (plan[r]) begin
      if (plan[r].what == ROW_LENGTH) begin
        write_length(plan[r].length);
      end else begin
        // The predictor runs on typed rows too, so its windows stay current.
        want = apply_item(plan[r].kind, plan[r].ch, plan[r].smp);
        if (plan[r].typed) want = plan[r].want;
        send_item(plan[r].kind, plan[r].ch, plan[r].smp, source_gap(), want);
      end
    end

    // Random phases. Each phase sets a window length, the extremes first, and
    // then mostly feeds one to three channels, so that rings fill up and wrap
    // and the oldest samples get overwritten. Clears are rare, and the sample
    // range changes so that sums both wrap and stay exact.
    items_left = RANDOM_ITEMS;
    phase = 0;
    while (items_left > 0) begin
      case (phase)
        0: new_length = 7'd64;
        1: new_length = 7'd1;
        2: new_length = 7'd127;
        3: new_length = 7'd0;
        4: new_length = 7'd2;
        5: new_length = 7'd65;
        default: begin
          if ($urandom_range(1) == 0) new_length = cnt_t'($urandom_range(WINDOW_DEPTH, 1));
          else new_length = cnt_t'($urandom_range(127));
        end
      endcase
      write_length(new_length);

      phase_items = $urandom_range(240, 120);
      if (phase_items > items_left) phase_items = items_left;
      items_left = items_left - phase_items;
      n_focus = $urandom_range(3, 1);
      for (ch_i = 0; ch_i < 3; ch_i++) focus[ch_i] = chan_t'($urandom_range(CHANNELS - 1));
      clear_pct = ($urandom_range(3) == 0) ? 10 : 2;
      smp_mode = $urandom_range(SMP_EXTREME);
      // Some phases run with no idling on one side or the other.
      src_gaps_on = ($urandom_range(3) != 0);
      stalls_on = ($urandom_range(3) != 0);

      repeat (phase_items) begin
        kind = ($urandom_range(99) < clear_pct) ? KIND_CLEAR : KIND_ADD;
        if ($urandom_range(99) < 85) ch = focus[$urandom_range(n_focus - 1)];
        else ch = chan_t'($urandom_range(CHANNELS - 1));
        case (smp_mode)
          SMP_FULL: smp = smp_t'($urandom_range(16'hFFFF));
          SMP_LOW:  smp = smp_t'($urandom_range(16'h00FF));
          SMP_HIGH: smp = smp_t'($urandom_range(16'hFFFF, 16'hFF00));
          default: begin
            roll = $urandom_range(2);
            if (roll == 0) smp = 16'h0000;
            else if (roll == 1) smp = 16'hFFFF;
            else smp = smp_t'($urandom_range(16'hFFFF));
          end
        endcase
        if (kind == KIND_ADD && !add_is_safe(ch)) kind = KIND_CLEAR;
        want = apply_item(kind, ch, smp);
        send_item(kind, ch, smp, source_gap(), want);
      end
      phase++;
    end

    // Let the last results arrive, then watch a while longer for stray ones.
    in_if.valid <= 1'b0;
    stalls_on = 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_stats.size() == 0)
      $display("window_sample_statistics_core verification clean");
    else
      $display("window_sample_statistics_core verification failed");
    $finish;
  end

endmodule
